// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bssd_pkg.sv =====
// types, constants and axis helper for the box signed distance unit
package bssd_pkg;

    localparam int COORD_W    = 32;
    localparam int IDX_W      = 6;
    localparam int MAX_BOXES  = 1 << IDX_W;
    localparam int CNT_W      = 7;
    localparam int BOX_W      = 4 * COORD_W;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SQRT_STEPS = COORD_W - 1;
    localparam int STEP_W     = $clog2(SQRT_STEPS);

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [CNT_W-1:0]   MAX_COUNT = CNT_W'(MAX_BOXES);
    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(SQRT_STEPS - 1);
    localparam logic [SQ_W-1:0]    SQ_LIMIT  = SQ_W'(1) << (SQ_W - 2);
    localparam logic [COORD_W-1:0] HALF      = COORD_W'(1) << (COORD_W - 1);
    localparam logic [COORD_W-1:0] MAX_POS   = HALF - COORD_W'(1);
    localparam logic [COORD_W-1:0] MIN_NEG   = HALF;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAP,
        ST_SQX,
        ST_SQY,
        ST_UPD,
        ST_FIN,
        ST_SQRT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] gap;
        logic [COORD_W-1:0] out_gap;
    } axis_t;

    // inside test, inside gap and capped outside gap along one axis
    function automatic axis_t axis_eval(coord_t lo, coord_t hi, coord_t p);
        logic signed [COORD_W:0] a;
        logic signed [COORD_W:0] b;
        logic signed [COORD_W:0] na;
        logic signed [COORD_W:0] nb;
        logic signed [COORD_W:0] m;
        logic signed [COORD_W:0] cap;
        axis_t r;
        cap = $signed({1'b0, HALF});
        a = {p[COORD_W-1], p} - {lo[COORD_W-1], lo};
        b = {hi[COORD_W-1], hi} - {p[COORD_W-1], p};
        na = -a;
        nb = -b;
        m = (na > nb) ? na : nb;
        r.hit = !a[COORD_W] && !b[COORD_W];
        r.gap = (a < b) ? a[COORD_W-1:0] : b[COORD_W-1:0];
        if (m[COORD_W])
        begin
            r.out_gap = '0;
        end
        else if (m > cap)
        begin
            r.out_gap = HALF;
        end
        else
        begin
            r.out_gap = m[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/box_set_signed_distance_unit.sv =====
// box set signed distance unit: minimum signed distance from a point to a box table
// a box write item gives no result
// a query visits each active box in turn (one table read and two passes through the
// shared multiplier each), then decides and runs 31 square root steps
// inside or saturated results skip the square root, and an empty table goes straight to output
// reset clears the control state and box_count; the box table holds no reset value
`include "assert_macros.svh"

module box_set_signed_distance_unit
    import bssd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [IDX_W-1:0]   box_index,
    input  coord_t             box_xmin,
    input  coord_t             box_xmax,
    input  coord_t             box_ymin,
    input  coord_t             box_ymax,
    input  coord_t             point_x,
    input  coord_t             point_y,
    output logic               out_valid,
    input  logic               out_ready,
    output coord_t             distance,
    output logic               empty_set,
    output logic               saturated
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] box_count_reg, box_count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic out_valid_reg, out_valid_next;

    coord_t px_reg, px_next;
    coord_t py_reg, py_next;
    logic inside_reg, inside_next;
    logic [COORD_W-1:0] dx_reg, dx_next;
    logic [COORD_W-1:0] dy_reg, dy_next;
    logic [COORD_W-1:0] gx_reg, gx_next;
    logic [COORD_W-1:0] gy_reg, gy_next;
    logic [COORD_W-1:0] gin_reg, gin_next;
    logic [SQ_W-1:0] prod_reg, prod_next;
    logic [SQ_W-1:0] xsq_reg, xsq_next;
    logic [SQ_W-1:0] best_reg, best_next;
    logic any_in_reg, any_in_next;
    logic [COORD_W-1:0] deep_reg, deep_next;
    logic [COORD_W:0] rem_reg, rem_next;
    logic [COORD_W-2:0] root_reg, root_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [COORD_W-1:0] res_dist_reg, res_dist_next;
    logic res_empty_reg, res_empty_next;
    logic res_sat_reg, res_sat_next;
    logic [COORD_W-1:0] dist_out_reg, dist_out_next;
    logic empty_out_reg, empty_out_next;
    logic sat_out_reg, sat_out_next;

    logic [CNT_W-1:0] count_n;
    logic in_fire;
    logic out_free;
    logic ram_we;
    logic [BOX_W-1:0] ram_wdata;
    logic [BOX_W-1:0] ram_rdata;
    coord_t rd_xmin, rd_xmax, rd_ymin, rd_ymax;
    axis_t ax, ay;
    logic [COORD_W-1:0] mul_op;
    logic [SQ_W-1:0] mul_out;
    logic [SQ_W:0] sq_sum;
    logic [COORD_W:0] rem_sh;
    logic [COORD_W:0] trial;
    logic [COORD_W-2:0] root_new;

    assign count_n   = (box_count_reg > MAX_COUNT) ? MAX_COUNT : box_count_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign ram_we    = in_fire && (req_type == REQ_WRITE);
    assign ram_wdata = {box_xmin, box_xmax, box_ymin, box_ymax};

    bssd_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_BOXES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (box_index),
        .wdata (ram_wdata),
        .raddr (idx_next[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_xmin = ram_rdata[4*COORD_W-1:3*COORD_W];
    assign rd_xmax = ram_rdata[3*COORD_W-1:2*COORD_W];
    assign rd_ymin = ram_rdata[2*COORD_W-1:COORD_W];
    assign rd_ymax = ram_rdata[COORD_W-1:0];

    assign ax = axis_eval(rd_xmin, rd_xmax, px_reg);
    assign ay = axis_eval(rd_ymin, rd_ymax, py_reg);

    // shared squaring unit
    assign mul_op  = (state_reg == ST_SQX) ? dx_reg : dy_reg;
    assign mul_out = SQ_W'(mul_op) * SQ_W'(mul_op);
    assign sq_sum  = {1'b0, xsq_reg} + {1'b0, prod_reg};

    // one digit of the square root
    assign rem_sh   = {rem_reg[COORD_W-2:0], best_reg[SQ_W-3:SQ_W-4]};
    assign trial    = {root_reg, 2'b01};
    assign root_new = {root_reg[COORD_W-3:0], (rem_sh >= trial)};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (req_type == REQ_QUERY))
                begin
                    state_next = (count_n == '0) ? ST_OUT : ST_GAP;
                end
            end
            ST_GAP:  state_next = ST_SQX;
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_UPD;
            ST_UPD:
            begin
                state_next = (idx_reg + CNT_W'(1) == count_n) ? ST_FIN : ST_GAP;
            end
            ST_FIN:
            begin
                state_next = (any_in_reg || (best_reg >= SQ_LIMIT)) ? ST_OUT : ST_SQRT;
            end
            ST_SQRT:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        box_count_next = cfg_we ? cfg_wdata : box_count_reg;
        idx_next       = idx_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        inside_next    = inside_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        gx_next        = gx_reg;
        gy_next        = gy_reg;
        gin_next       = gin_reg;
        prod_next      = prod_reg;
        xsq_next       = xsq_reg;
        best_next      = best_reg;
        any_in_next    = any_in_reg;
        deep_next      = deep_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        res_dist_next  = res_dist_reg;
        res_empty_next = res_empty_reg;
        res_sat_next   = res_sat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        dist_out_next  = dist_out_reg;
        empty_out_next = empty_out_reg;
        sat_out_next   = sat_out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (in_fire && (req_type == REQ_QUERY))
                begin
                    px_next        = point_x;
                    py_next        = point_y;
                    any_in_next    = 1'b0;
                    best_next      = SQ_LIMIT;
                    res_empty_next = 1'b0;
                    res_sat_next   = 1'b0;
                    if (count_n == '0)
                    begin
                        res_dist_next  = MAX_POS;
                        res_empty_next = 1'b1;
                    end
                end
            end
            ST_GAP:
            begin
                inside_next = ax.hit && ay.hit;
                dx_next     = ax.out_gap;
                dy_next     = ay.out_gap;
                gx_next     = ax.gap;
                gy_next     = ay.gap;
            end
            ST_SQX:
            begin
                prod_next = mul_out;
                gin_next  = (gx_reg < gy_reg) ? gx_reg : gy_reg;
            end
            ST_SQY:
            begin
                xsq_next  = prod_reg;
                prod_next = mul_out;
            end
            ST_UPD:
            begin
                idx_next = idx_reg + CNT_W'(1);
                if (inside_reg)
                begin
                    if (!any_in_reg || (gin_reg > deep_reg))
                    begin
                        deep_next = gin_reg;
                    end
                    any_in_next = 1'b1;
                end
                else if (sq_sum < {1'b0, best_reg})
                begin
                    best_next = sq_sum[SQ_W-1:0];
                end
            end
            ST_FIN:
            begin
                rem_next  = '0;
                root_next = '0;
                step_next = '0;
                if (any_in_reg)
                begin
                    if (deep_reg > HALF)
                    begin
                        res_dist_next = MIN_NEG;
                        res_sat_next  = 1'b1;
                    end
                    else
                    begin
                        res_dist_next = -deep_reg;
                    end
                end
                else if (best_reg >= SQ_LIMIT)
                begin
                    res_dist_next = MAX_POS;
                    res_sat_next  = 1'b1;
                end
            end
            ST_SQRT:
            begin
                rem_next  = (rem_sh >= trial) ? (rem_sh - trial) : rem_sh;
                root_next = root_new;
                best_next = best_reg << 2;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    res_dist_next = {1'b0, root_new};
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    dist_out_next  = res_dist_reg;
                    empty_out_next = res_empty_reg;
                    sat_out_next   = res_sat_reg;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            box_count_reg <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            box_count_reg <= box_count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg        <= px_next;
        py_reg        <= py_next;
        inside_reg    <= inside_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        gx_reg        <= gx_next;
        gy_reg        <= gy_next;
        gin_reg       <= gin_next;
        prod_reg      <= prod_next;
        xsq_reg       <= xsq_next;
        best_reg      <= best_next;
        any_in_reg    <= any_in_next;
        deep_reg      <= deep_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        step_reg      <= step_next;
        res_dist_reg  <= res_dist_next;
        res_empty_reg <= res_empty_next;
        res_sat_reg   <= res_sat_next;
        dist_out_reg  <= dist_out_next;
        empty_out_reg <= empty_out_next;
        sat_out_reg   <= sat_out_next;
    end

    assign out_valid = out_valid_reg;
    assign distance  = dist_out_reg;
    assign empty_set = empty_out_reg;
    assign saturated = sat_out_reg;

    `ASSERT_CLK(a_out_from_out_state, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == ST_OUT), "result item raised outside the output state")
    `ASSERT_NEXT(a_empty_query, clk, rst_n, in_fire && (req_type == REQ_QUERY) && (count_n == '0), state_reg == ST_OUT, "empty query did not go straight to output")
    `ASSERT_CLK(a_idx_in_range, clk, rst_n, (state_reg == ST_GAP) |-> (idx_reg < count_n), "box index past active count")
    `ASSERT_CLK(a_sqrt_rem_bound, clk, rst_n, (state_reg == ST_SQRT) |-> (rem_reg <= {1'b0, root_reg, 1'b0}), "square root remainder out of bound")

endmodule

// ===== rtl/core/bssd_ram.sv =====
// generic single write port ram with registered read
module bssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/box_set_signed_distance_unit_test.sv =====
// testbench for the box set signed distance unit: directed and random box writes and point queries
module box_set_signed_distance_unit_test
    import bssd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_CYCLES = 400;
    localparam coord_t UNIT = 32'sh0001_0000;
    localparam coord_t COORD_MIN = MIN_NEG;
    localparam coord_t COORD_MAX = MAX_POS;

    typedef struct {
        coord_t xmin;
        coord_t xmax;
        coord_t ymin;
        coord_t ymax;
    } box_edges_t;

    typedef struct {
        logic                kind;
        logic [IDX_W-1:0]    idx;
        box_edges_t          box;
        coord_t              px;
        coord_t              py;
    } box_req_t;

    typedef struct {
        coord_t sdist;
        logic   empty;
        logic   sat;
    } dist_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CNT_W-1:0]   cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               req_type = REQ_WRITE;
    logic [IDX_W-1:0]   box_index = '0;
    coord_t             box_xmin = '0;
    coord_t             box_xmax = '0;
    coord_t             box_ymin = '0;
    coord_t             box_ymax = '0;
    coord_t             point_x = '0;
    coord_t             point_y = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    coord_t             distance;
    logic               empty_set;
    logic               saturated;

    box_req_t       pending_reqs[$];
    dist_result_t   due_results[$];
    box_edges_t     stored_boxes[MAX_BOXES];
    box_edges_t     planned_boxes[MAX_BOXES];
    box_req_t       next_req;
    dist_result_t   got_result;
    dist_result_t   want_result;
    int             box_count_now = 0;
    int             idle_pct = 0;
    int             send_gap = 0;
    int             sink_gap = 0;
    logic           hold_off = 1'b0;
    int             accepted_items = 0;
    int             write_count = 0;
    int             query_count = 0;
    int             inside_count = 0;
    int             empty_count = 0;
    int             sat_count = 0;
    int             settings_seen = 0;
    int             mismatch_count = 0;
    int             cycle_count = 0;

    box_set_signed_distance_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .box_index (box_index),
        .box_xmin  (box_xmin),
        .box_xmax  (box_xmax),
        .box_ymin  (box_ymin),
        .box_ymax  (box_ymax),
        .point_x   (point_x),
        .point_y   (point_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .distance  (distance),
        .empty_set (empty_set),
        .saturated (saturated)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        mismatch_count++;
    endtask

    // gap from a point to a slab, zero inside, capped at half range
    function automatic logic [63:0] slab_gap(coord_t lo, coord_t hi, coord_t p);
        longint d;
        d = 0;
        if (longint'(lo) - longint'(p) > d)
            d = longint'(lo) - longint'(p);
        if (longint'(p) - longint'(hi) > d)
            d = longint'(p) - longint'(hi);
        if (d > (longint'(1) << (COORD_W - 1)))
            d = longint'(1) << (COORD_W - 1);
        return d;
    endfunction

    function automatic dist_result_t nearest_signed_distance(coord_t px, coord_t py);
        int           n;
        logic         in_box;
        longint       deepest;
        longint       g;
        logic [63:0]  dx;
        logic [63:0]  dy;
        logic [63:0]  sq;
        logic [63:0]  best;
        logic [63:0]  limit;
        logic [63:0]  root;
        logic [63:0]  trial;
        box_edges_t   b;
        dist_result_t r;
        n = (box_count_now > MAX_BOXES) ? MAX_BOXES : box_count_now;
        r.sdist = COORD_MAX;
        r.empty = 1'b0;
        r.sat = 1'b0;
        if (n == 0)
        begin
            r.empty = 1'b1;
            return r;
        end
        in_box = 1'b0;
        deepest = 0;
        limit = 64'd1 << (2 * COORD_W - 2);
        best = limit;
        for (int i = 0; i < n; i++)
        begin
            b = stored_boxes[i];
            if (px >= b.xmin && px <= b.xmax && py >= b.ymin && py <= b.ymax)
            begin
                g = longint'(px) - longint'(b.xmin);
                if (longint'(b.xmax) - longint'(px) < g)
                    g = longint'(b.xmax) - longint'(px);
                if (longint'(py) - longint'(b.ymin) < g)
                    g = longint'(py) - longint'(b.ymin);
                if (longint'(b.ymax) - longint'(py) < g)
                    g = longint'(b.ymax) - longint'(py);
                if (!in_box || g > deepest)
                    deepest = g;
                in_box = 1'b1;
            end
            else
            begin
                dx = slab_gap(b.xmin, b.xmax, px);
                dy = slab_gap(b.ymin, b.ymax, py);
                sq = dx * dx + dy * dy;
                if (sq < best)
                    best = sq;
            end
        end
        if (in_box)
        begin
            if (deepest > (longint'(1) << (COORD_W - 1)))
            begin
                deepest = longint'(1) << (COORD_W - 1);
                r.sat = 1'b1;
            end
            r.sdist = coord_t'(-deepest);
        end
        else if (best >= limit)
        begin
            r.sat = 1'b1;
        end
        else
        begin
            root = '0;
            for (int k = COORD_W - 2; k >= 0; k--)
            begin
                trial = root | (64'd1 << k);
                if (trial * trial <= best)
                    root = trial;
            end
            r.sdist = coord_t'(root);
        end
        return r;
    endfunction

    task automatic push_write(int idx, box_edges_t b);
        box_req_t q;
        q.kind = REQ_WRITE;
        q.idx = IDX_W'(idx);
        q.box = b;
        q.px = coord_t'($urandom);
        q.py = coord_t'($urandom);
        planned_boxes[idx] = b;
        pending_reqs.push_back(q);
    endtask

    task automatic push_query(coord_t px, coord_t py);
        box_req_t q;
        q.kind = REQ_QUERY;
        q.idx = IDX_W'($urandom);
        q.box = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom)};
        q.px = px;
        q.py = py;
        pending_reqs.push_back(q);
    endtask

    function automatic coord_t near_coord();
        return coord_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    endfunction

    function automatic coord_t edge_coord();
        case ($urandom_range(0, 3))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            default: return -1;
        endcase
    endfunction

    function automatic box_edges_t random_box();
        coord_t     cx;
        coord_t     cy;
        int         hx;
        int         hy;
        box_edges_t b;
        cx = near_coord();
        cy = near_coord();
        hx = $urandom_range(0, 1 << 18);
        hy = $urandom_range(0, 1 << 18);
        case ($urandom_range(0, 9))
            9: b = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                     coord_t'($urandom)};
            8: b = '{cx + hx + 1, cx - hx, cy + hy, cy - hy - 1};
            default: b = '{cx - hx, cx + hx, cy - hy, cy + hy};
        endcase
        return b;
    endfunction

    // point near the span of one active box, mostly inside it
    function automatic coord_t point_near(coord_t a, coord_t b);
        longint lo;
        longint hi;
        longint v;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        v = lo + longint'($urandom) % (hi - lo + 1);
        if ($urandom_range(0, 2) == 0)
            v = v + longint'($urandom_range(0, 1 << 18)) - (longint'(1) << 17);
        return coord_t'(v);
    endfunction

    task automatic push_random_item();
        int         n;
        int         i;
        box_edges_t b;
        n = (box_count_now > MAX_BOXES) ? MAX_BOXES : box_count_now;
        if ($urandom_range(0, 99) < 35)
        begin
            push_write($urandom_range(0, MAX_BOXES - 1), random_box());
            return;
        end
        case ($urandom_range(0, 9))
            6, 7: push_query(near_coord(), near_coord());
            8: push_query(coord_t'($urandom), coord_t'($urandom));
            9: push_query(edge_coord(), edge_coord());
            default:
            begin
                i = (n == 0) ? 0 : $urandom_range(0, n - 1);
                b = planned_boxes[i];
                push_query(point_near(b.xmin, b.xmax), point_near(b.ymin, b.ymax));
            end
        endcase
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic set_box_count(int value);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= CNT_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        box_count_now = value;
        settings_seen++;
        @(negedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_reqs.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                in_valid <= 1'b0;
                send_gap <= $urandom_range(0, 10);
            end
            else
            begin
                next_req = pending_reqs.pop_front();
                in_valid <= 1'b1;
                req_type <= next_req.kind;
                box_index <= next_req.idx;
                box_xmin <= next_req.box.xmin;
                box_xmax <= next_req.box.xmax;
                box_ymin <= next_req.box.ymin;
                box_ymax <= next_req.box.ymax;
                point_x <= next_req.px;
                point_y <= next_req.py;
            end
        end
    end

    // accepted items update the box table or queue an expected distance
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            accepted_items++;
            if (req_type == REQ_WRITE)
            begin
                stored_boxes[box_index] = '{box_xmin, box_xmax, box_ymin, box_ymax};
                write_count++;
            end
            else
            begin
                want_result = nearest_signed_distance(point_x, point_y);
                due_results.push_back(want_result);
                query_count++;
                if (want_result.sdist < 0)
                    inside_count++;
                if (want_result.empty)
                    empty_count++;
                if (want_result.sat)
                    sat_count++;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_gap <= 0;
        end
        else if (hold_off)
        begin
            out_ready <= 1'b0;
        end
        else if (sink_gap != 0)
        begin
            out_ready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            out_ready <= 1'b0;
            sink_gap <= $urandom_range(0, 10);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // long receiver stall while the sender keeps offering items
    initial
    begin
        wait (accepted_items >= 150);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d with no query pending", distance));
            end
            else
            begin
                got_result = due_results.pop_front();
                if (distance !== got_result.sdist)
                    report_mismatch($sformatf("distance %0d, expected %0d",
                                              distance, got_result.sdist));
                if (empty_set !== got_result.empty)
                    report_mismatch($sformatf("empty_set %0b, expected %0b",
                                              empty_set, got_result.empty));
                if (saturated !== got_result.sat)
                    report_mismatch($sformatf("saturated %0b, expected %0b",
                                              saturated, got_result.sat));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("box_set_signed_distance_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        int cnt;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        idle_pct <= 20;
        @(negedge clk);

        // empty table, then load the directed boxes
        push_query(COORD_MIN, COORD_MAX);
        push_write(0, '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN});
        push_write(63, '{-UNIT, UNIT, -UNIT, UNIT});
        push_write(1, '{10 * UNIT, 10 * UNIT, -7 * UNIT, -7 * UNIT});
        push_write(2, '{5 * UNIT, -5 * UNIT, 3 * UNIT, -3 * UNIT});
        push_write(3, '{0, 2 * UNIT, 0, 2 * UNIT});
        push_write(4, '{COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX});

        // far corner box alone: too far, on edge, rounding
        set_box_count(1);
        push_query(COORD_MAX, COORD_MAX);
        push_query(0, 0);
        push_query(COORD_MIN, COORD_MIN);
        push_query(COORD_MIN + UNIT, COORD_MIN);
        push_query(COORD_MIN + 1, COORD_MIN + 1);

        // point box, inverted box and a box two units wide
        set_box_count(4);
        push_query(UNIT, UNIT);
        push_query(0, UNIT);
        push_query(3 * UNIT, 2 * UNIT);
        push_query(0, 0);
        push_query(10 * UNIT, -7 * UNIT);
        push_query(-UNIT, -UNIT);
        push_query(6 * UNIT, 4 * UNIT);

        // full range box: deepest inside gap
        set_box_count(5);
        push_query(-1, -1);
        push_query(COORD_MAX, COORD_MIN);
        push_query(0, 0);

        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0: cnt = 5;
                1: cnt = 127;
                2: cnt = 0;
                3: cnt = 64;
                4: cnt = 1;
                default: cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 127)
                                                           : $urandom_range(1, 6);
            endcase
            set_box_count(cnt);
            if (p == 9)
            begin
                idle_pct <= 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: idle_pct <= 0;
                    1: idle_pct <= 15;
                    default: idle_pct <= 40;
                endcase
            end
            if (p == 0)
                for (int i = 0; i < MAX_BOXES; i++)
                    push_write(i, random_box());
            for (int j = 0; j < 136; j++)
                push_random_item();
        end

        while (pending_reqs.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d queries never answered", due_results.size()));

        $display("ran %0d box writes and %0d queries over %0d box_count settings",
                 write_count, query_count, settings_seen);
        $display("queries: %0d inside a box, %0d on an empty set, %0d saturated",
                 inside_count, empty_count, sat_count);
        if (mismatch_count == 0)
        begin
            $display("box_set_signed_distance_unit: match");
        end
        else
        begin
            $display("box_set_signed_distance_unit: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bssd_pkg.sv
rtl/core/bssd_ram.sv
rtl/core/box_set_signed_distance_unit.sv
tb/box_set_signed_distance_unit_test.sv
